@@ rtl/core/dac_pkg.sv @@
// Shared types, constants and calendar helpers of the date alarm countdown.
`default_nettype none

package dac_pkg;

  localparam int unsigned CntW    = 34;  // signed working count
  localparam int unsigned RemW    = 33;  // signed remaining_seconds field
  localparam int unsigned NowW    = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned ZoneW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 12;
  localparam int unsigned OutDatW = 40;

  localparam logic [YearW-1:0]  YearMin  = 12'd1970;
  localparam logic [YearW-1:0]  YearMax  = 12'd2099;
  localparam logic [MonthW-1:0] MonthMin = 4'd1;
  localparam logic [MonthW-1:0] MonthMax = 4'd12;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;

  localparam logic [CntW-1:0] SecPerDay      = 34'd86400;
  localparam logic [CntW-1:0] SecPerYear     = 34'd31536000;
  localparam logic [CntW-1:0] SecPerLeapYear = 34'd31622400;

  // Item kind carried in tuser.
  localparam logic FuncArm  = 1'b0;
  localparam logic FuncTick = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegYear   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMonth  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDay    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHour   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinute = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSecond = 3'd5;
  localparam logic [CfgIdxW-1:0] RegZone   = 3'd6;

  typedef struct packed {
    logic [YearW-1:0]        year;
    logic [MonthW-1:0]       month;
    logic [DayW-1:0]         day;
    logic [HourW-1:0]        hour;
    logic [MinW-1:0]         minute;
    logic [SecW-1:0]         second;
    logic signed [ZoneW-1:0] zone;
  } cfg_t;

  typedef struct packed {
    logic            fired;
    logic            arm_error;
    logic [RemW-1:0] remaining;
  } res_t;

  // Leap test for years of the clamped range 1970..2099 only. Inside that
  // range the century exceptions never change the answer (2000 is a leap
  // year by the 400 rule), so divisibility by four decides it.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  // Seconds in a common-year month, 1 is January.
  function automatic logic [CntW-1:0] month_secs(input logic [MonthW-1:0] m);
    logic [CntW-1:0] s;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = 34'd2678400;
      4'd4, 4'd6, 4'd9, 4'd11:                    s = 34'd2592000;
      4'd2:                                       s = 34'd2419200;
      default:                                    s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dac_core.sv @@
// Sequencer and shared adder that convert the target date and run the count.
`default_nettype none

module dac_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      func_i,
  input  wire logic [dac_pkg::NowW-1:0]  now_i,
  input  wire dac_pkg::cfg_t             cfg_i,
  output logic                           ready_o,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output dac_pkg::res_t                  res_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StYear   = 4'd1;
  localparam logic [3:0] StMonth  = 4'd2;
  localparam logic [3:0] StLeap   = 4'd3;
  localparam logic [3:0] StDay    = 4'd4;
  localparam logic [3:0] StHour   = 4'd5;
  localparam logic [3:0] StMinSec = 4'd6;
  localparam logic [3:0] StNow    = 4'd7;
  localparam logic [3:0] StTick   = 4'd8;
  localparam logic [3:0] StFin    = 4'd9;

  logic [3:0]                        state_q, state_d;
  logic signed [dac_pkg::CntW-1:0]   count_q, count_d;
  logic                              armed_q, armed_d;
  logic                              func_q, func_d;
  logic                              dec_q, dec_d;
  logic [dac_pkg::NowW-1:0]          now_q, now_d;
  logic [dac_pkg::YearW-1:0]         yr_q, yr_d;
  logic [dac_pkg::MonthW-1:0]        mo_q, mo_d;

  logic [dac_pkg::YearW-1:0]         y_lim;
  logic [dac_pkg::MonthW-1:0]        m_lim;
  logic [dac_pkg::DayW-1:0]          day_m1;
  logic [21:0]                       day_term;
  logic signed [6:0]                 hz;
  logic signed [19:0]                hour_term;
  logic [11:0]                       minsec_term;

  logic [dac_pkg::CntW-1:0]          opnd;
  logic                              sub;
  logic [dac_pkg::CntW-1:0]          sum;
  logic                              cnt_zero;
  logic                              arm_err;

  // Clamped year and month, and the small per-field terms.
  always_comb begin
    y_lim = cfg_i.year;
    if (cfg_i.year < dac_pkg::YearMin) y_lim = dac_pkg::YearMin;
    if (cfg_i.year > dac_pkg::YearMax) y_lim = dac_pkg::YearMax;
    m_lim = cfg_i.month;
    if (cfg_i.month < dac_pkg::MonthMin) m_lim = dac_pkg::MonthMin;
    if (cfg_i.month > dac_pkg::MonthMax) m_lim = dac_pkg::MonthMax;
  end

  assign day_m1      = (cfg_i.day == '0) ? '0 : cfg_i.day - 5'd1;
  assign day_term    = 22'(day_m1) * 22'd86400;
  assign hz          = $signed({2'b00, cfg_i.hour}) - 7'(cfg_i.zone);
  assign hour_term   = 20'(hz) * 20'sd3600;
  assign minsec_term = 12'(cfg_i.minute) * 12'd60 + 12'(cfg_i.second);

  // The shared adder that accumulates the count.
  assign sum = count_q + (sub ? ~opnd : opnd) + dac_pkg::CntW'(sub);

  assign cnt_zero = (count_q == '0);
  assign arm_err  = count_q[dac_pkg::CntW-1] | cnt_zero;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    armed_d = armed_q;
    func_d  = func_q;
    dec_d   = dec_q;
    now_d   = now_q;
    yr_d    = yr_q;
    mo_d    = mo_q;
    opnd    = '0;
    sub     = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          func_d = func_i;
          now_d  = now_i;
          dec_d  = 1'b0;
          if (func_i == dac_pkg::FuncArm) begin
            count_d = '0;
            yr_d    = dac_pkg::YearMin;
            mo_d    = dac_pkg::MonthMin;
            state_d = StYear;
          end else if (armed_q) begin
            state_d = StTick;
          end else begin
            state_d = StFin;
          end
        end
      end
      StYear: begin
        if (yr_q == y_lim) begin
          state_d = StMonth;
        end else begin
          opnd    = dac_pkg::is_leap(yr_q) ? dac_pkg::SecPerLeapYear : dac_pkg::SecPerYear;
          count_d = sum;
          yr_d    = yr_q + 12'd1;
        end
      end
      StMonth: begin
        if (mo_q == m_lim) begin
          state_d = StLeap;
        end else begin
          opnd    = dac_pkg::month_secs(mo_q);
          count_d = sum;
          mo_d    = mo_q + 4'd1;
        end
      end
      StLeap: begin
        opnd    = ((m_lim > dac_pkg::MonthFeb) && dac_pkg::is_leap(y_lim)) ?
                  dac_pkg::SecPerDay : '0;
        count_d = sum;
        state_d = StDay;
      end
      StDay: begin
        opnd    = dac_pkg::CntW'(day_term);
        count_d = sum;
        state_d = StHour;
      end
      StHour: begin
        opnd    = dac_pkg::CntW'(hour_term);
        count_d = sum;
        state_d = StMinSec;
      end
      StMinSec: begin
        opnd    = dac_pkg::CntW'(minsec_term);
        count_d = sum;
        state_d = StNow;
      end
      StNow: begin
        opnd    = {2'b00, now_q};
        sub     = 1'b1;
        count_d = sum;
        state_d = StFin;
      end
      StTick: begin
        opnd    = dac_pkg::CntW'(1);
        sub     = 1'b1;
        count_d = sum;
        dec_d   = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        if (res_ready_i) begin
          state_d = StIdle;
          if (func_q == dac_pkg::FuncArm) begin
            armed_d = ~arm_err;
          end else if (dec_q) begin
            armed_d = ~cnt_zero;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      armed_q <= 1'b0;
      func_q  <= dac_pkg::FuncArm;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      armed_q <= armed_d;
      func_q  <= func_d;
      dec_q   <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    yr_q  <= yr_d;
    mo_q  <= mo_d;
  end

  assign ready_o     = (state_q == StIdle);
  assign res_valid_o = (state_q == StFin);

  // Result fields; the count can only fall below -2^32 on an arm error.
  always_comb begin
    res_o.fired     = (func_q == dac_pkg::FuncTick) & dec_q & cnt_zero;
    res_o.arm_error = (func_q == dac_pkg::FuncArm) & arm_err;
    case (count_q[dac_pkg::CntW-1 -: 2])
      2'b10:   res_o.remaining = {1'b1, {(dac_pkg::RemW-1){1'b0}}};
      2'b01:   res_o.remaining = {1'b0, {(dac_pkg::RemW-1){1'b1}}};
      default: res_o.remaining = count_q[dac_pkg::RemW-1:0];
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/date_alarm_countdown.sv @@
// Top level of the date alarm countdown: configuration, stream ports, result register.
`default_nettype none

// A one-second countdown alarm aimed at a calendar date and time. Seven
// configuration registers hold the target year, month, day, local hour,
// minute, second and the zone offset in hours ahead of UTC; the year is
// clamped to 1970..2099 and the month to 1..12. An arm beat (tuser 0)
// carries the current Unix time in tdata; the block converts the target to
// Unix seconds and loads the difference as the remaining count. A count that
// is not positive raises arm_error and leaves the alarm disarmed. A tick
// beat (tuser 1) decrements the count while armed, and the beat that brings
// it to zero reports fired and disarms. Every input beat yields exactly one
// result beat. The count arithmetic runs through one shared 34-bit adder under a
// small sequencer that adds one year per cycle, then one month per cycle,
// then the leap day, day, hour and minute/second terms, then subtracts the
// current time. The input is not ready while an arm or a tick is worked and
// until its result is handed over. A finished result waits in an output
// register, so the next beat is taken while the previous result is still
// being held off by the downstream side. Configuration writes are accepted
// in every cycle and must only be made while no beat is in flight.

module date_alarm_countdown (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dac_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [dac_pkg::CfgDatW-1:0]    cfg_data_i,
  // Input stream.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [dac_pkg::NowW-1:0]       s_axis_tdata,  // [31:0] now_seconds
  input  wire logic [0:0]                     s_axis_tuser,  // [0] func
  // Result stream.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [dac_pkg::OutDatW-1:0]         m_axis_tdata   // [0] fired, [1] arm_error,
                                                             // [34:2] remaining_seconds
);

  dac_pkg::cfg_t  cfg_q;
  dac_pkg::res_t  res;
  dac_pkg::res_t  out_q;
  logic           out_valid_q;
  logic           core_ready;
  logic           res_valid;
  logic           res_ready;
  logic           in_fire;

  // Configuration registers. Writes to indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.year   <= dac_pkg::YearMin;
      cfg_q.month  <= dac_pkg::MonthMin;
      cfg_q.day    <= 5'd1;
      cfg_q.hour   <= '0;
      cfg_q.minute <= '0;
      cfg_q.second <= '0;
      cfg_q.zone   <= 5'sd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dac_pkg::RegYear:   cfg_q.year   <= cfg_data_i;
        dac_pkg::RegMonth:  cfg_q.month  <= cfg_data_i[dac_pkg::MonthW-1:0];
        dac_pkg::RegDay:    cfg_q.day    <= cfg_data_i[dac_pkg::DayW-1:0];
        dac_pkg::RegHour:   cfg_q.hour   <= cfg_data_i[dac_pkg::HourW-1:0];
        dac_pkg::RegMinute: cfg_q.minute <= cfg_data_i[dac_pkg::MinW-1:0];
        dac_pkg::RegSecond: cfg_q.second <= cfg_data_i[dac_pkg::SecW-1:0];
        dac_pkg::RegZone:   cfg_q.zone   <= $signed(cfg_data_i[dac_pkg::ZoneW-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = core_ready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  // The core hands its result over once the output register is free or
  // is being emptied in this cycle.
  assign res_ready = ~out_valid_q | m_axis_tready;

  dac_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .func_i      (s_axis_tuser[0]),
    .now_i       (s_axis_tdata),
    .cfg_i       (cfg_q),
    .ready_o     (core_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.remaining, out_q.arm_error, out_q.fired};

  // A new beat is only taken when the core has no result left to hand over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !res_valid)
    else $error("input beat accepted while a result is pending in the core");

  // A firing tick always leaves a zero count behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.fired) |-> (res.remaining == '0))
    else $error("fired reported with a nonzero remaining count");

  // An arm error means the stored difference is zero or negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.arm_error) |->
      (res.remaining[dac_pkg::RemW-1] || (res.remaining == '0)))
    else $error("arm error reported with a positive remaining count");

  // The output register is loaded only by a core handover.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res_valid))
    else $error("result register loaded without a core result");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench of the date alarm countdown, checked against a beat-level predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 7 names no register; writes there must leave the target unchanged.
  localparam logic [dac_pkg::CfgIdxW-1:0] RegSpare = 3'd7;

  // Even 2000 arms, each walking the full year range and waiting out
  // receiver stalls and sender gaps, stay far below this limit.
  localparam int unsigned LimitCycles = 2000000;
  localparam int unsigned ItemTarget  = 1900;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 200;

  localparam longint RemMax = 64'sd4294967295;
  localparam longint RemMin = -64'sd4294967296;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [dac_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [dac_pkg::CfgDatW-1:0]  cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [dac_pkg::NowW-1:0]     s_axis_tdata  = '0;
  logic [0:0]                   s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [dac_pkg::OutDatW-1:0]  m_axis_tdata;

  // Shadow of the target registers and of the countdown state.
  dac_pkg::cfg_t                   alarm_cfg;
  logic signed [dac_pkg::CntW-1:0] count_left;
  logic                            alarm_armed;

  dac_pkg::res_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   live_items     = 0;
  int unsigned   cycle_count    = 0;
  bit            gaps_on        = 1'b1;
  logic          rx_hold        = 1'b0;
  event          hold_start;

  date_alarm_countdown i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Full Gregorian rule, so the predictor does not lean on the clamped year range.
  function automatic bit leap_year(input int yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Unix seconds (UTC) of the programmed local target time.
  function automatic longint calendar_to_unix(input dac_pkg::cfg_t c);
    int     yr;
    int     mo;
    longint secs;
    yr = int'(c.year);
    mo = int'(c.month);
    if (yr < 1970) yr = 1970;
    if (yr > 2099) yr = 2099;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    secs = 0;
    for (int y = 1970; y < yr; y++) begin
      secs += leap_year(y) ? 64'sd31622400 : 64'sd31536000;
    end
    for (int m = 1; m < mo; m++) begin
      case (m)
        2:           secs += 28 * 86400;
        4, 6, 9, 11: secs += 30 * 86400;
        default:     secs += 31 * 86400;
      endcase
    end
    if (mo > 2 && leap_year(yr)) secs += 86400;
    if (c.day > 1) secs += (longint'(c.day) - 1) * 86400;
    secs += (longint'(c.hour) - longint'($signed(c.zone))) * 3600;
    secs += longint'(c.minute) * 60 + longint'(c.second);
    return secs;
  endfunction

  // Advances the countdown state by one accepted beat and returns its result.
  function automatic dac_pkg::res_t apply_beat(input logic func,
                                               input logic [dac_pkg::NowW-1:0] now);
    dac_pkg::res_t r;
    longint        diff;
    longint        wide;
    r = '0;
    if (func == dac_pkg::FuncArm) begin
      diff        = calendar_to_unix(alarm_cfg) - longint'(now);
      count_left  = dac_pkg::CntW'(diff);
      r.arm_error = (diff <= 0);
      alarm_armed = (diff > 0);
    end else if (alarm_armed) begin
      count_left = count_left - 1;
      if (count_left == 0) begin
        r.fired     = 1'b1;
        alarm_armed = 1'b0;
      end
    end
    wide = longint'(count_left);
    if (wide > RemMax) wide = RemMax;
    else if (wide < RemMin) wide = RemMin;
    r.remaining = wide[dac_pkg::RemW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0d ns mismatch: %0s", $time, msg);
  endtask

  // Receiver side: random stalls, none during the quiet stretch, all during a hold-off.
  always @(negedge clk_i) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (gaps_on) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always begin
    @(hold_start);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Every result beat is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    dac_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.fired)
          report_mismatch($sformatf("fired got %0b expected %0b", m_axis_tdata[0], want.fired));
        if (m_axis_tdata[1] !== want.arm_error)
          report_mismatch($sformatf("arm_error got %0b expected %0b",
                                    m_axis_tdata[1], want.arm_error));
        if (m_axis_tdata[dac_pkg::RemW+1:2] !== want.remaining)
          report_mismatch($sformatf("remaining_seconds got %0d expected %0d",
                                    $signed(m_axis_tdata[dac_pkg::RemW+1:2]),
                                    $signed(want.remaining)));
      end
    end
  end

  // Offers one beat, with random gaps ahead of it, and leaves tvalid high on return.
  task automatic send_beat(input logic func, input logic [dac_pkg::NowW-1:0] now);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    live_items++;
    pending_results.push_back(apply_beat(func, now));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [dac_pkg::CfgIdxW-1:0] idx,
                           input logic [dac_pkg::CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      dac_pkg::RegYear:   alarm_cfg.year   = data[dac_pkg::YearW-1:0];
      dac_pkg::RegMonth:  alarm_cfg.month  = data[dac_pkg::MonthW-1:0];
      dac_pkg::RegDay:    alarm_cfg.day    = data[dac_pkg::DayW-1:0];
      dac_pkg::RegHour:   alarm_cfg.hour   = data[dac_pkg::HourW-1:0];
      dac_pkg::RegMinute: alarm_cfg.minute = data[dac_pkg::MinW-1:0];
      dac_pkg::RegSecond: alarm_cfg.second = data[dac_pkg::SecW-1:0];
      dac_pkg::RegZone:   alarm_cfg.zone   = data[dac_pkg::ZoneW-1:0];
      default:   ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_target(input int yr, input int mo, input int dy, input int hr,
                                input int mi, input int se, input int zn);
    write_reg(dac_pkg::RegYear,   dac_pkg::CfgDatW'(yr));
    write_reg(dac_pkg::RegMonth,  dac_pkg::CfgDatW'(mo));
    write_reg(dac_pkg::RegDay,    dac_pkg::CfgDatW'(dy));
    write_reg(dac_pkg::RegHour,   dac_pkg::CfgDatW'(hr));
    write_reg(dac_pkg::RegMinute, dac_pkg::CfgDatW'(mi));
    write_reg(dac_pkg::RegSecond, dac_pkg::CfgDatW'(se));
    write_reg(dac_pkg::RegZone,   dac_pkg::CfgDatW'(zn));
  endtask

  // Reset target lies eight hours before the epoch, so every arm fails.
  task automatic test_reset_state();
    send_beat(dac_pkg::FuncTick, '0);
    send_beat(dac_pkg::FuncArm, '0);
    send_beat(dac_pkg::FuncArm, '1);           // difference falls below the 33-bit floor
    send_beat(dac_pkg::FuncTick, 32'hA5A5_5A5A);
  endtask

  task automatic test_countdown_to_fire();
    wait_idle();
    write_reg(dac_pkg::RegZone, dac_pkg::CfgDatW'(0));
    write_reg(dac_pkg::RegSecond, dac_pkg::CfgDatW'(5));
    send_beat(dac_pkg::FuncArm, 32'd0);
    repeat (5) send_beat(dac_pkg::FuncTick, '1);
    send_beat(dac_pkg::FuncTick, '0);          // disarmed after firing
    send_beat(dac_pkg::FuncArm, 32'd2);
    send_beat(dac_pkg::FuncTick, '0);
    send_beat(dac_pkg::FuncArm, 32'd4);        // re-arm while still counting
    send_beat(dac_pkg::FuncTick, '0);
    send_beat(dac_pkg::FuncArm, 32'd5);        // target equals now
    send_beat(dac_pkg::FuncArm, 32'd6);        // target in the past
    send_beat(dac_pkg::FuncTick, '0);
  endtask

  task automatic test_calendar_limits();
    wait_idle();
    program_target(4095, 15, 31, 31, 63, 63, -16);
    send_beat(dac_pkg::FuncArm, '0);
    send_beat(dac_pkg::FuncArm, '1);
    wait_idle();
    program_target(0, 0, 0, 0, 0, 0, 15);
    send_beat(dac_pkg::FuncArm, '0);
    wait_idle();
    program_target(2000, 3, 1, 0, 0, 0, 0);   // day after the leap day of a 400-year
    send_beat(dac_pkg::FuncArm, '0);
    wait_idle();
    program_target(2100, 12, 31, 23, 59, 59, 14);
    send_beat(dac_pkg::FuncArm, '0);
  endtask

  // The receiver holds off long enough for the block to fill and refuse input.
  task automatic test_output_backpressure();
    wait_idle();
    program_target(2030, 6, 15, 12, 0, 0, 0);
    send_beat(dac_pkg::FuncArm, 32'd1_800_000_000);
    -> hold_start;
    repeat (24) send_beat(dac_pkg::FuncTick, $urandom);
  endtask

  task automatic test_random_traffic();
    int unsigned                 phase;
    longint                      goal;
    longint                      start;
    int                          lead;
    logic [dac_pkg::NowW-1:0]    now;
    logic [dac_pkg::CfgDatW-1:0] val;
    phase = 0;
    while (live_items < ItemTarget) begin
      wait_idle();
      gaps_on = !(phase >= 20 && phase < 45);
      for (int r = int'(dac_pkg::RegYear); r <= int'(dac_pkg::RegZone); r++) begin
        if (phase == 0 || $urandom_range(0, 2) == 0) begin
          case (dac_pkg::CfgIdxW'(r))
            dac_pkg::RegYear:
              val = ($urandom_range(0, 9) == 0) ? dac_pkg::CfgDatW'($urandom_range(0, 4095))
                                                : dac_pkg::CfgDatW'($urandom_range(1970, 2099));
            dac_pkg::RegMonth:  val = dac_pkg::CfgDatW'($urandom_range(0, 15));
            dac_pkg::RegDay:    val = dac_pkg::CfgDatW'($urandom_range(0, 31));
            dac_pkg::RegHour:   val = dac_pkg::CfgDatW'($urandom_range(0, 31));
            dac_pkg::RegMinute: val = dac_pkg::CfgDatW'($urandom_range(0, 63));
            dac_pkg::RegSecond: val = dac_pkg::CfgDatW'($urandom_range(0, 63));
            default:            val = dac_pkg::CfgDatW'($urandom_range(0, 31));
          endcase
          write_reg(dac_pkg::CfgIdxW'(r), val);
        end
      end
      if ($urandom_range(0, 19) == 0) write_reg(RegSpare, dac_pkg::CfgDatW'($urandom));
      goal = calendar_to_unix(alarm_cfg);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) < 7) begin
          // Arm a short way before the target and tick it down to zero, at times a little past.
          lead  = $urandom_range(1, 25);
          start = goal - lead;
          now   = (start >= 0 && start <= 64'sd4294967295) ? dac_pkg::NowW'(start)
                                                          : dac_pkg::NowW'($urandom);
          send_beat(dac_pkg::FuncArm, now);
          repeat (lead + $urandom_range(0, 2)) begin
            if ($urandom_range(0, 29) == 0)
              send_beat(dac_pkg::FuncArm, dac_pkg::NowW'(now + $urandom_range(0, 3)));
            else send_beat(dac_pkg::FuncTick, dac_pkg::NowW'($urandom));
          end
        end else begin
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1) == 0)
              send_beat(dac_pkg::FuncTick, dac_pkg::NowW'($urandom));
            else if ($urandom_range(0, 1) == 0)
              send_beat(dac_pkg::FuncArm, dac_pkg::NowW'($urandom));
            else send_beat(dac_pkg::FuncArm, dac_pkg::NowW'(goal + $urandom_range(0, 4) - 2));
          end
        end
      end
      phase++;
    end
  endtask

  initial begin
    alarm_cfg.year   = dac_pkg::YearMin;
    alarm_cfg.month  = dac_pkg::MonthMin;
    alarm_cfg.day    = 5'd1;
    alarm_cfg.hour   = '0;
    alarm_cfg.minute = '0;
    alarm_cfg.second = '0;
    alarm_cfg.zone   = 5'sd8;
    count_left       = '0;
    alarm_armed      = 1'b0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_countdown_to_fire();
    test_calendar_limits();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
